// File: src/drp_pkg.sv
// shared types, constants and a helper function for the directory record parser
// no dependencies; compiled first
`timescale 1ns / 1ps

package drp_pkg;

    localparam int MIN_BLOCK_LOG2 = 9;
    localparam int MAX_BLOCK_LOG2 = 16;
    localparam int BLOCK_BYTES_W  = MAX_BLOCK_LOG2 + 1;
    localparam int POS_W          = 16;
    localparam int LOG2_W         = 5;

    localparam logic [LOG2_W-1:0] BLOCK_LOG2_RESET  = LOG2_W'(MIN_BLOCK_LOG2);
    localparam logic [POS_W-1:0]  MIN_RECORD_LENGTH = POS_W'(8);
    localparam logic [POS_W-1:0]  NAME_OFFSET       = POS_W'(8);

    // record field offsets
    localparam logic [POS_W-1:0] OFS_LENGTH_LO = POS_W'(4);
    localparam logic [POS_W-1:0] OFS_LENGTH_HI = POS_W'(5);
    localparam logic [POS_W-1:0] OFS_TYPE      = POS_W'(6);
    localparam logic [POS_W-1:0] OFS_NAMLEN    = POS_W'(7);

    // result kinds
    localparam logic [1:0] KIND_HEADER     = 2'd0;
    localparam logic [1:0] KIND_NAME       = 2'd1;
    localparam logic [1:0] KIND_BAD_LENGTH = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [31:0]      inode_number;
        logic [7:0]       entry_type;
        logic [7:0]       name_length;
        logic [7:0]       name_byte;
        logic [POS_W-1:0] record_offset;
        logic             last_of_entry;
    } result_t;

    // block size in bytes, log2 clamped to the supported range
    function automatic logic [BLOCK_BYTES_W-1:0] block_bytes(input logic [LOG2_W-1:0] lg);
        logic [LOG2_W-1:0] c;
        c = lg;
        if (c < LOG2_W'(MIN_BLOCK_LOG2))
            c = LOG2_W'(MIN_BLOCK_LOG2);
        if (c > LOG2_W'(MAX_BLOCK_LOG2))
            c = LOG2_W'(MAX_BLOCK_LOG2);
        return BLOCK_BYTES_W'(1) << c;
    endfunction

endpackage

// File: src/drp_ifs.sv
// handshake interfaces for the directory record parser: byte in, result out, config write
// no dependencies
`timescale 1ns / 1ps

interface drp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
    modport monitor (input valid, input data_byte, input ready);
endinterface

interface drp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] inode_number;
    logic [7:0]  entry_type;
    logic [7:0]  name_length;
    logic [7:0]  name_byte;
    logic [15:0] record_offset;
    logic        last_of_entry;

    modport source (output valid, output kind, output inode_number, output entry_type,
                    output name_length, output name_byte, output record_offset,
                    output last_of_entry, input ready);
    modport sink   (input valid, input kind, input inode_number, input entry_type,
                    input name_length, input name_byte, input record_offset,
                    input last_of_entry, output ready);
    modport monitor (input valid, input kind, input inode_number, input entry_type,
                     input name_length, input name_byte, input record_offset,
                     input last_of_entry, input ready);
endinterface

interface drp_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] block_size_log2;

    modport source (output valid, output block_size_log2, input ready);
    modport sink   (input valid, input block_size_log2, output ready);
    modport monitor (input valid, input block_size_log2, input ready);
endinterface

// File: src/directory_record_parser.sv
// top level of the directory record parser: handshakes, config register, result register
// depends on drp_pkg, drp_ifs and drp_core
`timescale 1ns / 1ps

// Directory record parser. Bytes of directory blocks arrive one item per cycle on
// bytes; the block walks the little-endian records (inode number, record length,
// type, name length, name) and puts at most one result per byte on results: an
// entry header when a live entry's name-length byte arrives, one result per name
// byte (names cut at the record end), or a bad-length result, after which the rest
// of the block is skipped. Throughput is one byte per cycle while the sink keeps up;
// a result appears in the cycle after its byte is taken, set by the single result
// register. bytes.ready drops only while that register holds a result the sink has
// not taken. The block size (log2, clamped to 9..16, reset 9) is written on cfg,
// which is always ready; write it only while the stream is idle.
module directory_record_parser (
    input logic          clk,
    input logic          rst_n,
    drp_byte_if.sink     bytes,
    drp_result_if.source results,
    drp_cfg_if.sink      cfg
);
    import drp_pkg::*;

    logic [LOG2_W-1:0] log2_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg,       out_next;

    logic              accept;
    logic              core_valid;
    result_t           core_result;

    // config write channel never stalls
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            log2_reg <= BLOCK_LOG2_RESET;
        else if (cfg.valid)
            log2_reg <= cfg.block_size_log2;
    end

    // take a byte whenever the result slot is empty or draining this cycle
    assign bytes.ready = !out_valid_reg || results.ready;
    assign accept      = bytes.valid && bytes.ready;

    drp_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (bytes.data_byte),
        .bsize        (block_bytes(log2_reg)),
        .result_valid (core_valid),
        .result       (core_result)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (accept)
        begin
            out_valid_next = core_valid;
            if (core_valid)
                out_next = core_result;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload carries no reset
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign results.valid         = out_valid_reg;
    assign results.kind          = out_reg.kind;
    assign results.inode_number  = out_reg.inode_number;
    assign results.entry_type    = out_reg.entry_type;
    assign results.name_length   = out_reg.name_length;
    assign results.name_byte     = out_reg.name_byte;
    assign results.record_offset = out_reg.record_offset;
    assign results.last_of_entry = out_reg.last_of_entry;

endmodule

// File: src/drp_core.sv
// record walker: parse state registers and the per-byte field decode
// depends on drp_pkg
`timescale 1ns / 1ps

module drp_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [7:0]                          data_byte,
    input  logic [drp_pkg::BLOCK_BYTES_W-1:0]   bsize,
    output logic                                result_valid,
    output drp_pkg::result_t                    result
);
    import drp_pkg::*;

    logic [POS_W-1:0] blk_pos_reg,   blk_pos_next;
    logic [POS_W-1:0] rec_pos_reg,   rec_pos_next;
    logic [POS_W-1:0] rec_start_reg, rec_start_next;
    logic [POS_W-1:0] rec_len_reg,   rec_len_next;
    logic [31:0]      inode_reg,     inode_next;
    logic [7:0]       type_reg,      type_next;
    logic [7:0]       namlen_reg,    namlen_next;
    logic             abandoned_reg, abandoned_next;

    logic                     block_end;
    logic [POS_W-1:0]         len_full;
    logic [BLOCK_BYTES_W-1:0] room;
    logic [7:0]               namlen_src;
    logic [POS_W-1:0]         name_room;
    logic [7:0]               usable;
    logic [POS_W-1:0]         idx;
    logic [POS_W:0]           rp_plus1;

    assign block_end  = ({1'b0, blk_pos_reg} + 17'd1) >= bsize;
    assign len_full   = {data_byte, rec_len_reg[7:0]};
    assign room       = (bsize > {1'b0, rec_start_reg}) ? (bsize - {1'b0, rec_start_reg})
                                                        : '0;
    assign namlen_src = (rec_pos_reg == OFS_NAMLEN) ? data_byte : namlen_reg;
    assign name_room  = rec_len_reg - NAME_OFFSET;
    assign usable     = ({8'd0, namlen_src} < name_room) ? namlen_src : name_room[7:0];
    assign idx        = rec_pos_reg - NAME_OFFSET;
    assign rp_plus1   = {1'b0, rec_pos_reg} + 17'd1;

    always_comb
    begin
        blk_pos_next   = blk_pos_reg;
        rec_pos_next   = rec_pos_reg;
        rec_start_next = rec_start_reg;
        rec_len_next   = rec_len_reg;
        inode_next     = inode_reg;
        type_next      = type_reg;
        namlen_next    = namlen_reg;
        abandoned_next = abandoned_reg;

        result_valid          = 1'b0;
        result.kind           = KIND_HEADER;
        result.inode_number   = inode_reg;
        result.entry_type     = type_reg;
        result.name_length    = namlen_reg;
        result.name_byte      = 8'd0;
        result.record_offset  = rec_start_reg;
        result.last_of_entry  = 1'b0;

        if (!abandoned_reg)
        begin
            if (rec_pos_reg < OFS_LENGTH_LO)
            begin
                case (rec_pos_reg[1:0])
                    2'd0:    inode_next = {24'd0, data_byte};
                    2'd1:    inode_next[15:8]  = data_byte;
                    2'd2:    inode_next[23:16] = data_byte;
                    default: inode_next[31:24] = data_byte;
                endcase
            end
            else if (rec_pos_reg == OFS_LENGTH_LO)
            begin
                rec_len_next = {8'd0, data_byte};
            end
            else if (rec_pos_reg == OFS_LENGTH_HI)
            begin
                rec_len_next = len_full;
                if (len_full < MIN_RECORD_LENGTH || {1'b0, len_full} > room)
                begin
                    result_valid         = 1'b1;
                    result.kind          = KIND_BAD_LENGTH;
                    result.entry_type    = 8'd0;
                    result.name_length   = 8'd0;
                    abandoned_next       = 1'b1;
                end
            end
            else if (rec_pos_reg == OFS_TYPE)
            begin
                type_next = data_byte;
            end
            else if (rec_pos_reg == OFS_NAMLEN)
            begin
                namlen_next = data_byte;
                if (inode_reg != 32'd0)
                begin
                    result_valid         = 1'b1;
                    result.kind          = KIND_HEADER;
                    result.name_length   = data_byte;
                    result.last_of_entry = (usable == 8'd0);
                end
            end
            else if (inode_reg != 32'd0 && idx < {8'd0, usable})
            begin
                result_valid         = 1'b1;
                result.kind          = KIND_NAME;
                result.name_byte     = data_byte;
                result.last_of_entry = ((idx + 16'd1) == {8'd0, usable});
            end

            // step to the next byte, or to the next record at its end
            if (!abandoned_next)
            begin
                if (rec_pos_reg >= OFS_NAMLEN && rp_plus1 >= {1'b0, rec_len_reg})
                begin
                    rec_start_next = rec_start_reg + rec_len_reg;
                    rec_pos_next   = '0;
                end
                else
                begin
                    rec_pos_next = rp_plus1[POS_W-1:0];
                end
            end
        end

        if (block_end)
        begin
            blk_pos_next   = '0;
            rec_pos_next   = '0;
            rec_start_next = '0;
            abandoned_next = 1'b0;
        end
        else
        begin
            blk_pos_next = blk_pos_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_pos_reg   <= '0;
            rec_pos_reg   <= '0;
            rec_start_reg <= '0;
            rec_len_reg   <= '0;
            inode_reg     <= '0;
            type_reg      <= '0;
            namlen_reg    <= '0;
            abandoned_reg <= 1'b0;
        end
        else if (accept)
        begin
            blk_pos_reg   <= blk_pos_next;
            rec_pos_reg   <= rec_pos_next;
            rec_start_reg <= rec_start_next;
            rec_len_reg   <= rec_len_next;
            inode_reg     <= inode_next;
            type_reg      <= type_next;
            namlen_reg    <= namlen_next;
            abandoned_reg <= abandoned_next;
        end
    end

endmodule

// File: src/drp_checker.sv
// port-level assertions for the directory record parser, bound to the top level
// depends on drp_pkg
`timescale 1ns / 1ps

module drp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  res_kind,
    input logic [31:0] res_inode_number,
    input logic [7:0]  res_entry_type,
    input logic [7:0]  res_name_length,
    input logic [7:0]  res_name_byte,
    input logic [15:0] res_record_offset,
    input logic        res_last_of_entry,
    input logic        cfg_valid,
    input logic        cfg_ready
);
    import drp_pkg::*;

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid
            && $stable(res_kind) && $stable(res_inode_number)
            && $stable(res_name_byte) && $stable(res_record_offset)
            && $stable(res_last_of_entry)))
        else $error("stalled result changed");

    // no result appears without a byte taken the cycle before
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (!(byte_valid && byte_ready) && !(res_valid && !res_ready))
            |=> !res_valid)
        else $error("result without an input byte");

    // input stalls only behind a waiting result
    a_ready_rate: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> (res_valid && !res_ready))
        else $error("input stalled with result slot free");

    // bad-length results carry no entry details
    a_bad_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_kind == KIND_BAD_LENGTH) |->
            (res_entry_type == 8'd0 && res_name_length == 8'd0
             && res_name_byte == 8'd0 && !res_last_of_entry))
        else $error("bad-length result with entry fields set");

    // config port never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind directory_record_parser drp_checker u_drp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .byte_valid        (bytes.valid),
    .byte_ready        (bytes.ready),
    .res_valid         (results.valid),
    .res_ready         (results.ready),
    .res_kind          (results.kind),
    .res_inode_number  (results.inode_number),
    .res_entry_type    (results.entry_type),
    .res_name_length   (results.name_length),
    .res_name_byte     (results.name_byte),
    .res_record_offset (results.record_offset),
    .res_last_of_entry (results.last_of_entry),
    .cfg_valid         (cfg.valid),
    .cfg_ready         (cfg.ready)
);

// File: tb/sv/tb_top.sv
// testbench for the directory record parser: byte stream in, entry results out
// depends on drp_pkg, drp_ifs and directory_record_parser
`timescale 1ns / 1ps

module tb_top;

    import drp_pkg::*;

    // quiet cycles allowed before the watchdog gives up
    localparam int STALL_LIMIT   = 2000;
    // cycles to let the result register settle before a register write or the end
    localparam int SETTLE_CYCLES = 6;
    // long receiver hold-off used to back up the input
    localparam int HOLD_CYCLES   = 300;

    // expected-result tracker: walks the byte stream exactly as the parser should
    class dir_parse_scoreboard;
        logic [4:0]  size_log2;
        logic [15:0] blk_pos;
        logic [15:0] rec_pos;
        logic [15:0] rec_start;
        logic [15:0] rec_len;
        logic [31:0] inode;
        logic [7:0]  type_b;
        logic [7:0]  namlen;
        bit          abandoned;
        result_t     expected_results[$];
        int          failures;

        function new();
            size_log2 = BLOCK_LOG2_RESET;
            blk_pos   = '0;
            rec_pos   = '0;
            rec_start = '0;
            rec_len   = '0;
            inode     = '0;
            type_b    = '0;
            namlen    = '0;
            abandoned = 1'b0;
            failures  = 0;
        endfunction

        static function int unsigned bytes_per_block(logic [4:0] lg);
            int unsigned c;
            c = lg;
            if (c < MIN_BLOCK_LOG2)
                c = MIN_BLOCK_LOG2;
            if (c > MAX_BLOCK_LOG2)
                c = MAX_BLOCK_LOG2;
            return 32'd1 << c;
        endfunction

        function void set_block_log2(logic [4:0] v);
            size_log2 = v;
        endfunction

        // name bytes that fit inside the record
        function int unsigned usable_name();
            int unsigned room;
            room = int'(rec_len) - 8;
            return (namlen < room) ? namlen : room;
        endfunction

        function void expect_result(logic [1:0] k, logic [7:0] typ, logic [7:0] nl,
                                    logic [7:0] nb, bit last);
            result_t r;
            r.kind          = k;
            r.inode_number  = inode;
            r.entry_type    = typ;
            r.name_length   = nl;
            r.name_byte     = nb;
            r.record_offset = rec_start;
            r.last_of_entry = last;
            expected_results.push_back(r);
        endfunction

        // called for every accepted input item
        function void take_byte(logic [7:0] b);
            int unsigned bsize;
            int unsigned pos;
            int unsigned rp;
            int unsigned room;
            int unsigned idx;
            int unsigned n;
            bit          blk_end;
            bsize   = bytes_per_block(size_log2);
            pos     = blk_pos;
            rp      = rec_pos;
            blk_end = (pos + 1 >= bsize);

            if (!abandoned) begin
                if (rp < 4) begin
                    if (rp == 0)
                        inode = 32'(b);
                    else
                        inode = inode | (32'(b) << (8 * rp));
                end else if (rp == OFS_LENGTH_LO) begin
                    rec_len = 16'(b);
                end else if (rp == OFS_LENGTH_HI) begin
                    room    = (bsize > rec_start) ? bsize - rec_start : 0;
                    rec_len = rec_len | (16'(b) << 8);
                    if (rec_len < MIN_RECORD_LENGTH || rec_len > room) begin
                        expect_result(KIND_BAD_LENGTH, 8'h00, 8'h00, 8'h00, 1'b0);
                        abandoned = 1'b1;
                    end
                end else if (rp == OFS_TYPE) begin
                    type_b = b;
                end else if (rp == OFS_NAMLEN) begin
                    namlen = b;
                    if (inode != 0)
                        expect_result(KIND_HEADER, type_b, namlen, 8'h00, usable_name() == 0);
                end else if (inode != 0) begin
                    idx = rp - NAME_OFFSET;
                    n   = usable_name();
                    if (idx < n)
                        expect_result(KIND_NAME, type_b, namlen, b, idx + 1 == n);
                end

                if (!abandoned) begin
                    if (rp >= OFS_NAMLEN && rp + 1 >= rec_len) begin
                        rec_start = rec_start + rec_len;
                        rec_pos   = '0;
                    end else begin
                        rec_pos = 16'(rp + 1);
                    end
                end
            end

            if (blk_end) begin
                blk_pos   = '0;
                rec_pos   = '0;
                rec_start = '0;
                abandoned = 1'b0;
            end else begin
                blk_pos = blk_pos + 16'd1;
            end
        endfunction

        function void report(string what, result_t want, result_t got);
            failures++;
            if (failures <= 10)
                $display("%s (expected/actual): kind %0d/%0d inode %h/%h type %h/%h namlen %0d/%0d byte %h/%h offset %0d/%0d last %0d/%0d",
                         what, want.kind, got.kind, want.inode_number, got.inode_number,
                         want.entry_type, got.entry_type, want.name_length, got.name_length,
                         want.name_byte, got.name_byte, want.record_offset, got.record_offset,
                         want.last_of_entry, got.last_of_entry);
        endfunction

        // called for every accepted result
        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                report("result with nothing expected", '0, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.inode_number !== want.inode_number ||
                got.entry_type !== want.entry_type || got.name_length !== want.name_length ||
                got.name_byte !== want.name_byte || got.record_offset !== want.record_offset ||
                got.last_of_entry !== want.last_of_entry)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    drp_byte_if   byte_ch();
    drp_result_if result_ch();
    drp_cfg_if    cfg_ch();

    directory_record_parser u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    dir_parse_scoreboard sb = new();

    // byte stream waiting to be sent, built a phase at a time
    logic [7:0]  dir_stream_q[$];
    // generator's own view of the block: where the next byte lands
    int unsigned gen_pos;
    logic [4:0]  gen_log2;
    // bytes the parser actually walks (skipped bytes of an abandoned block not counted)
    int          walked_bytes;
    // sender without gaps while set
    bit          steady_sender;
    // receiver hold-off, counted down by the receiver process
    int          hold_left;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // stream generation
    // ---------------------------------------------------------------

    // queue one byte and advance the generator position, wrapping at the block end
    task automatic put_byte(logic [7:0] b, bit walked);
        dir_stream_q.push_back(b);
        if (walked)
            walked_bytes++;
        if (gen_pos + 1 >= dir_parse_scoreboard::bytes_per_block(gen_log2))
            gen_pos = 0;
        else
            gen_pos++;
    endtask

    // one record: header fields, then the body; a bad length gets the rest of the
    // block as filler, since the parser skips it anyway
    task automatic put_record(logic [31:0] ino, logic [15:0] reclen, logic [7:0] typ,
                              logic [7:0] nl);
        int unsigned left;
        left = dir_parse_scoreboard::bytes_per_block(gen_log2) - gen_pos;
        for (int i = 0; i < 4; i++)
            put_byte(ino[8*i +: 8], 1'b1);
        put_byte(reclen[7:0], 1'b1);
        put_byte(reclen[15:8], 1'b1);
        put_byte(typ, 1'b1);
        put_byte(nl, 1'b1);
        if (reclen < MIN_RECORD_LENGTH || reclen > left) begin
            while (gen_pos != 0)
                put_byte(8'($urandom), 1'b0);
        end else begin
            repeat (int'(reclen) - 8)
                put_byte(8'($urandom), 1'b1);
        end
    endtask

    // mostly well-formed records with random content; some noise near block ends
    task automatic random_record();
        int unsigned bsize;
        int unsigned left;
        int unsigned reclen;
        int unsigned nl;
        int unsigned pick;
        logic [31:0] ino;
        bsize = dir_parse_scoreboard::bytes_per_block(gen_log2);
        // block shrank under the current position: the next byte ends the block
        if (gen_pos >= bsize) begin
            put_byte(8'($urandom), 1'b1);
            return;
        end
        left = bsize - gen_pos;
        // too little room for a header: the block end cuts it off
        if (left < 8) begin
            repeat (left)
                put_byte(8'($urandom), 1'b1);
            return;
        end

        pick = $urandom_range(0, 99);
        if (pick < 10)
            ino = '0;                   // dead entry
        else if (pick < 14)
            ino = '1;
        else
            ino = $urandom;

        pick = $urandom_range(0, 99);
        if (pick < 75)
            nl = $urandom_range(0, 16);
        else if (pick < 95)
            nl = $urandom_range(17, 64);
        else
            nl = $urandom_range(65, 255);

        // aligned record, sometimes with slack; usually the last one fills the block
        reclen = (8 + nl + 3) & ~32'd3;
        if ($urandom_range(0, 3) == 0)
            reclen += $urandom_range(0, 24);
        if (reclen > left || (left - reclen < 8 && $urandom_range(0, 3) != 0))
            reclen = left;

        // declared name runs past the record end
        if ($urandom_range(0, 9) == 0 && reclen - 8 < 255) begin
            nl = reclen - 8 + $urandom_range(1, 40);
            if (nl > 255)
                nl = 255;
        end

        // bad record length, kept near the block end so the skipped tail stays short
        if (left <= 200 && $urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 2))
                0:       reclen = $urandom_range(0, 7);
                1:       reclen = left + $urandom_range(1, 300);
                default: reclen = 32'hFFFF;
            endcase
        end

        put_record(ino, 16'(reclen), 8'($urandom), 8'(nl));
    endtask

    task automatic run_random(int budget);
        int target;
        target = walked_bytes + budget;
        while (walked_bytes < target)
            random_record();
    endtask

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // send the queued bytes in bursts with random gaps, or with no gaps while steady_sender is set
    task automatic send_stream();
        int burst_left;
        int gap_left;
        burst_left = $urandom_range(1, 48);
        gap_left   = 0;
        @(negedge clk);
        while (dir_stream_q.size() > 0) begin
            if (gap_left > 0 && !steady_sender) begin
                byte_ch.valid     <= 1'b0;
                byte_ch.data_byte <= 8'($urandom);
                gap_left--;
                @(negedge clk);
            end else begin
                byte_ch.valid     <= 1'b1;
                byte_ch.data_byte <= dir_stream_q[0];
                @(posedge clk);
                while (!byte_ch.ready)
                    @(posedge clk);
                sb.take_byte(dir_stream_q.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    // now and then a long burst with no idling at all
                    if ($urandom_range(0, 4) == 0)
                        burst_left = $urandom_range(100, 300);
                    else
                        burst_left = $urandom_range(1, 48);
                    gap_left = $urandom_range(1, 7);
                end
                @(negedge clk);
            end
        end
        byte_ch.valid <= 1'b0;
    endtask

    // wait until every expected result is back and the block has gone quiet
    task automatic wait_idle();
        while (sb.expected_results.size() != 0 || byte_ch.valid)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_block_log2(logic [4:0] v);
        wait_idle();
        @(negedge clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.block_size_log2 <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_block_log2(v);
        gen_log2 = v;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // receiver: stall pattern of its own, plus a long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin
        int rx_mode;
        int rx_tick;
        rx_mode = 0;
        rx_tick = 0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                case (rx_mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       result_ch.ready <= ((rx_tick % 9) < 5);
                    default: result_ch.ready <= ($urandom_range(0, 1) != 0);
                endcase
            end
            rx_tick++;
            if (rx_tick % 400 == 0)
                rx_mode = $urandom_range(0, 3);
        end
    end

    // result monitor: every accepted result goes to the scoreboard
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            got.kind          = result_ch.kind;
            got.inode_number  = result_ch.inode_number;
            got.entry_type    = result_ch.entry_type;
            got.name_length   = result_ch.name_length;
            got.name_byte     = result_ch.name_byte;
            got.record_offset = result_ch.record_offset;
            got.last_of_entry = result_ch.last_of_entry;
            sb.check_result(got);
        end
    end

    // watchdog: too long without any handshake ends the run
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n                  = 1'b0;
        byte_ch.valid          = 1'b0;
        byte_ch.data_byte      = 8'h00;
        result_ch.ready        = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.block_size_log2 = BLOCK_LOG2_RESET;
        gen_pos                = 0;
        gen_log2               = BLOCK_LOG2_RESET;
        walked_bytes           = 0;
        steady_sender          = 1'b0;
        hold_left              = 0;

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // smallest block, written explicitly
        write_block_log2(5'd9);

        // directed: all-ones inode with an empty name (header is last of entry)
        put_record(32'hFFFF_FFFF, 16'd8, 8'hFF, 8'd0);
        // dead entry: no results, length still checked
        put_record(32'h0000_0000, 16'd8, 8'h00, 8'd4);
        // declared name longer than the record: only two name bytes come out
        put_record(32'h0000_0001, 16'd10, 8'h01, 8'd255);
        // bad length: error item, rest of the block skipped
        put_record(32'h1234_5678, 16'hFFFF, 8'h02, 8'd3);
        run_random(150);
        send_stream();

        // below range acts as the smallest block; receiver holds off while the
        // sender keeps offering, so the block backs up and stalls its input
        write_block_log2(5'd0);
        hold_left     = HOLD_CYCLES;
        steady_sender = 1'b1;
        run_random(200);
        send_stream();
        steady_sender = 1'b0;

        // above range acts as the largest block; go well past the small block size
        write_block_log2(5'd31);
        while (gen_pos < 600)
            random_record();
        send_stream();

        // shrink under the current position: the next byte ends the block
        write_block_log2(5'd9);
        run_random(150);
        send_stream();

        write_block_log2(5'd12);
        run_random(150);
        send_stream();

        write_block_log2(5'd16);
        run_random(100);
        send_stream();

        wait_idle();
        if (sb.failures == 0 && sb.expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: directory_record_parser.f
src/drp_pkg.sv
src/drp_ifs.sv
src/drp_core.sv
src/directory_record_parser.sv
src/drp_checker.sv
tb/sv/tb_top.sv
